// File: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
package jse_pkg;

  localparam int unsigned OPS_PER_ITEM = 4;

  localparam logic [1:0] OP_ONE  = 2'd0;
  localparam logic [1:0] OP_ESC2 = 2'd1;
  localparam logic [1:0] OP_UESC = 2'd2;

  localparam logic [15:0] CH_QUOTE  = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_U      = 16'h0075;
  localparam logic [15:0] CH_B      = 16'h0062;
  localparam logic [15:0] CH_F      = 16'h0066;
  localparam logic [15:0] CH_N      = 16'h006E;
  localparam logic [15:0] CH_R      = 16'h0072;
  localparam logic [15:0] CH_T      = 16'h0074;
  localparam logic [15:0] CTRL_LIMIT = 16'h0020;
  localparam logic [15:0] SURR_BASE  = 16'hD800;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        done;
  } jse_op_t;

  typedef struct packed {
    jse_op_t [OPS_PER_ITEM-1:0] ops;
    logic [2:0]                 count;
  } jse_plan_t;

  function automatic logic is_high(input logic [15:0] u);
    return u[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [15:0] u);
    return u[15:10] == 6'b110111;
  endfunction

  function automatic logic [2:0] op_len(input logic [1:0] kind);
    logic [2:0] len;
    unique case (kind)
      OP_ONE:  len = 3'd1;
      OP_ESC2: len = 3'd2;
      OP_UESC: len = 3'd6;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] hex_digit(input logic [3:0] nib);
    logic [15:0] d;
    if (nib < 4'd10) begin
      d = 16'h0030 + {12'd0, nib};
    end else begin
      d = 16'h0057 + {12'd0, nib};
    end
    return d;
  endfunction

endpackage

// File: rtl/core/jse_in_if.sv
`timescale 1ns / 1ps
interface jse_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first_unit;
  logic        last_unit;
  logic        no_unit;

  modport source (output valid, output code_unit, output first_unit, output last_unit,
                  output no_unit, input ready);
  modport sink (input valid, input code_unit, input first_unit, input last_unit,
                input no_unit, output ready);
endinterface

// File: rtl/core/jse_out_if.sv
`timescale 1ns / 1ps
interface jse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output out_unit, output run_last, output string_done,
                  input ready);
  modport sink (input valid, input out_unit, input run_last, input string_done,
                output ready);
endinterface

// File: rtl/core/jse_front.sv
`timescale 1ns / 1ps
module jse_front
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_ch,
  output logic      plan_valid,
  output jse_plan_t plan,
  input  logic      plan_ready
);

  logic       high_held_r, high_held_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       accept;
  jse_plan_t  plan_c;

  assign in_ch.ready = plan_ready;
  assign accept      = in_ch.valid && plan_ready;

  always_comb begin
    logic        held;
    logic [9:0]  bits;
    logic [2:0]  n;
    logic [15:0] c;
    logic [15:0] esc;
    held   = high_held_r;
    bits   = held_bits_r;
    n      = 3'd0;
    c      = in_ch.code_unit;
    esc    = 16'd0;
    plan_c = '0;

    if (in_ch.first_unit) begin
      if (held) begin
        plan_c.ops[n[1:0]] = '{kind: OP_UESC, value: SURR_BASE | {6'd0, bits}, done: 1'b0};
        n    = n + 3'd1;
        held = 1'b0;
        bits = 10'd0;
      end
      plan_c.ops[n[1:0]] = '{kind: OP_ONE, value: CH_QUOTE, done: 1'b0};
      n = n + 3'd1;
    end

    if (!in_ch.no_unit) begin
      if (held && is_low(c)) begin
        plan_c.ops[n[1:0]] = '{kind: OP_ONE, value: SURR_BASE | {6'd0, bits}, done: 1'b0};
        n = n + 3'd1;
        plan_c.ops[n[1:0]] = '{kind: OP_ONE, value: c, done: 1'b0};
        n    = n + 3'd1;
        held = 1'b0;
        bits = 10'd0;
      end else begin
        if (held) begin
          plan_c.ops[n[1:0]] = '{kind: OP_UESC, value: SURR_BASE | {6'd0, bits}, done: 1'b0};
          n    = n + 3'd1;
          held = 1'b0;
          bits = 10'd0;
        end
        unique case (c)
          CH_QUOTE:  esc = CH_QUOTE;
          CH_BSLASH: esc = CH_BSLASH;
          16'h0008:  esc = CH_B;
          16'h000C:  esc = CH_F;
          16'h000A:  esc = CH_N;
          16'h000D:  esc = CH_R;
          16'h0009:  esc = CH_T;
          default:   esc = 16'd0;
        endcase
        if (esc != 16'd0) begin
          plan_c.ops[n[1:0]] = '{kind: OP_ESC2, value: esc, done: 1'b0};
          n = n + 3'd1;
        end else if (is_high(c)) begin
          held = 1'b1;
          bits = c[9:0];
        end else if (c < CTRL_LIMIT || is_low(c)) begin
          plan_c.ops[n[1:0]] = '{kind: OP_UESC, value: c, done: 1'b0};
          n = n + 3'd1;
        end else begin
          plan_c.ops[n[1:0]] = '{kind: OP_ONE, value: c, done: 1'b0};
          n = n + 3'd1;
        end
      end
    end

    if (in_ch.last_unit) begin
      if (held) begin
        plan_c.ops[n[1:0]] = '{kind: OP_UESC, value: SURR_BASE | {6'd0, bits}, done: 1'b0};
        n    = n + 3'd1;
        held = 1'b0;
        bits = 10'd0;
      end
      plan_c.ops[n[1:0]] = '{kind: OP_ONE, value: CH_QUOTE, done: 1'b1};
      n = n + 3'd1;
    end

    plan_c.count  = n;
    high_held_nxt = held;
    held_bits_nxt = bits;
  end

  assign plan       = plan_c;
  assign plan_valid = in_ch.valid && (plan_c.count != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_held_r <= 1'b0;
      held_bits_r <= 10'd0;
    end else if (accept) begin
      high_held_r <= high_held_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

endmodule

// File: rtl/core/jse_queue.sv
`timescale 1ns / 1ps
module jse_queue
  import jse_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  jse_plan_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output jse_plan_t pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jse_plan_t         mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/jse_back.sv
`timescale 1ns / 1ps
module jse_back
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      plan_valid,
  output logic      plan_pop,
  input  jse_plan_t plan,
  jse_out_if.source out_ch
);

  logic [1:0]  op_idx_r;
  logic [2:0]  sub_idx_r;
  logic        out_valid_r;
  logic [15:0] out_unit_r;
  logic        run_last_r;
  logic        string_done_r;

  jse_op_t     cur;
  logic [2:0]  cur_len;
  logic        last_sub, last_op, load;
  logic [15:0] unit_c;

  assign cur      = plan.ops[op_idx_r];
  assign cur_len  = op_len(cur.kind);
  assign last_sub = (sub_idx_r + 3'd1) == cur_len;
  assign last_op  = ({1'b0, op_idx_r} + 3'd1) == plan.count;
  assign load     = plan_valid && (!out_valid_r || out_ch.ready);
  assign plan_pop = load && last_sub && last_op;

  always_comb begin
    unit_c = cur.value;
    if (cur.kind == OP_ESC2) begin
      unit_c = (sub_idx_r == 3'd0) ? CH_BSLASH : cur.value;
    end else if (cur.kind == OP_UESC) begin
      case (sub_idx_r)
        3'd0:    unit_c = CH_BSLASH;
        3'd1:    unit_c = CH_U;
        3'd2:    unit_c = hex_digit(cur.value[15:12]);
        3'd3:    unit_c = hex_digit(cur.value[11:8]);
        3'd4:    unit_c = hex_digit(cur.value[7:4]);
        default: unit_c = hex_digit(cur.value[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit_r    <= unit_c;
      run_last_r    <= last_sub && last_op;
      string_done_r <= last_sub && cur.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      op_idx_r    <= 2'd0;
      sub_idx_r   <= 3'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      if (last_sub) begin
        sub_idx_r <= 3'd0;
        op_idx_r  <= last_op ? 2'd0 : op_idx_r + 2'd1;
      end else begin
        sub_idx_r <= sub_idx_r + 3'd1;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_unit    = out_unit_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.string_done = string_done_r;

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid |-> sub_idx_r < cur_len)
    else $error("unit index past end of op");

  a_op_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid |-> {1'b0, op_idx_r} < plan.count)
    else $error("op index past end of plan");

  a_idle_indices: assert property (@(posedge clk) disable iff (!rst_n)
    !plan_valid |-> (op_idx_r == 2'd0 && sub_idx_r == 3'd0))
    else $error("indices not rewound between plans");

  a_done_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && string_done_r) |-> (out_unit_r == CH_QUOTE && run_last_r))
    else $error("closing mark on a word that is not the final quote");

endmodule

// File: rtl/core/json_string_escaper.sv
`timescale 1ns / 1ps
// An accepted word's plan is queued; its first result word is then registered at the output.
// Throughput: one result word per cycle while out_ch.ready holds; an input word is taken
// every cycle while the plan queue has room, so the pace is set by the single output
// port and by the escape expansion of each input word.
// Reset: synchronous active-low rst_n empties the queue and drops any held high surrogate.
module json_string_escaper
  import jse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_ch,
  jse_out_if.source out_ch
);

  logic      f_valid, f_ready;
  jse_plan_t f_plan;
  logic      q_valid, q_pop;
  jse_plan_t q_plan;

  jse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .plan_valid (f_valid),
    .plan       (f_plan),
    .plan_ready (f_ready)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_plan),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_plan)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (q_valid),
    .plan_pop   (q_pop),
    .plan       (q_plan),
    .out_ch     (out_ch)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import jse_pkg::*;

  localparam logic [15:0] CTL_BSP = 16'h0008;
  localparam logic [15:0] CTL_TAB = 16'h0009;
  localparam logic [15:0] CTL_LF = 16'h000A;
  localparam logic [15:0] CTL_FF = 16'h000C;
  localparam logic [15:0] CTL_CR = 16'h000D;
  localparam logic [15:0] PRINT_LAST = 16'h007E;
  localparam logic [15:0] HIGH_LAST = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST = 16'hDC00;
  localparam logic [15:0] LOW_LAST = 16'hDFFF;
  localparam logic [127:0] HEX_ASCII = "0123456789abcdef";
  localparam logic [6:0][15:0] ESC_SET = {CH_QUOTE, CH_BSLASH, CTL_BSP, CTL_TAB, CTL_LF,
                                          CTL_FF, CTL_CR};
  localparam int IDLE_PCT = 27;
  localparam int HOLD_AT = 180;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [15:0] unit;
    logic        first;
    logic        last;
    logic        none;
    logic        drain;
  } str_word_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        run_last;
    logic        done;
  } esc_word_t;

  logic clk;
  logic rst_n;

  jse_in_if in_ch ();
  jse_out_if out_ch ();

  json_string_escaper dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  str_word_t   words_to_send[$];
  esc_word_t   escaped_expect[$];
  logic        high_pending = 1'b0;
  logic [9:0]  high_bits = '0;
  logic        drain_next = 1'b0;
  int          sent_cnt = 0;
  int          n_items = 0;
  int          err_cnt = 0;
  int          cycles = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  assign calm = (sent_cnt >= 60) && (sent_cnt < 110);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic add_word(input logic [15:0] u, input logic done);
    esc_word_t w;
    w.unit = u;
    w.run_last = 1'b0;
    w.done = done;
    escaped_expect.insert(escaped_expect.size(), w);
  endtask

  task automatic add_u_escape(input logic [15:0] u);
    add_word(CH_BSLASH, 1'b0);
    add_word(CH_U, 1'b0);
    for (int k = 3; k >= 0; k--) begin
      add_word({8'd0, HEX_ASCII[8 * (15 - int'(u[4 * k +: 4])) +: 8]}, 1'b0);
    end
  endtask

  task automatic flush_high();
    if (high_pending) begin
      add_u_escape(SURR_BASE | {6'd0, high_bits});
      high_pending = 1'b0;
      high_bits = '0;
    end
  endtask

  task automatic escape_word(input logic [15:0] u, input logic first, input logic last,
                             input logic none);
    int        n0;
    logic [15:0] short_esc;
    n0 = escaped_expect.size();
    if (first) begin
      flush_high();
      add_word(CH_QUOTE, 1'b0);
    end
    if (!none) begin
      if (high_pending && u >= LOW_FIRST && u <= LOW_LAST) begin
        add_word(SURR_BASE | {6'd0, high_bits}, 1'b0);
        add_word(u, 1'b0);
        high_pending = 1'b0;
        high_bits = '0;
      end else begin
        flush_high();
        case (u)
          CH_QUOTE:  short_esc = CH_QUOTE;
          CH_BSLASH: short_esc = CH_BSLASH;
          CTL_BSP:   short_esc = CH_B;
          CTL_FF:    short_esc = CH_F;
          CTL_LF:    short_esc = CH_N;
          CTL_CR:    short_esc = CH_R;
          CTL_TAB:   short_esc = CH_T;
          default:   short_esc = '0;
        endcase
        if (short_esc != '0) begin
          add_word(CH_BSLASH, 1'b0);
          add_word(short_esc, 1'b0);
        end else if (u >= SURR_BASE && u <= HIGH_LAST) begin
          high_pending = 1'b1;
          high_bits = u[9:0];
        end else if (u < CTRL_LIMIT || (u >= LOW_FIRST && u <= LOW_LAST)) begin
          add_u_escape(u);
        end else begin
          add_word(u, 1'b0);
        end
      end
    end
    if (last) begin
      flush_high();
      add_word(CH_QUOTE, 1'b1);
    end
    if (escaped_expect.size() > n0) begin
      escaped_expect[escaped_expect.size() - 1].run_last = 1'b1;
    end
  endtask

  task automatic queue_word(input logic [15:0] u, input logic first, input logic last,
                            input logic none);
    str_word_t w;
    w.unit = u;
    w.first = first;
    w.last = last;
    w.none = none;
    w.drain = drain_next;
    drain_next = 1'b0;
    words_to_send.insert(words_to_send.size(), w);
  endtask

  always @(posedge clk) begin : drive_in
    str_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sent_cnt <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        escape_word(in_ch.code_unit, in_ch.first_unit, in_ch.last_unit, in_ch.no_unit);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (words_to_send.size() != 0
            && !(words_to_send[0].drain && escaped_expect.size() != 0)
            && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          w = words_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.code_unit <= w.unit;
          in_ch.first_unit <= w.first;
          in_ch.last_unit <= w.last;
          in_ch.no_unit <= w.none;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_out
    esc_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (escaped_expect.size() == 0) begin
        $error("unexpected word: out_unit %h run_last %b string_done %b", out_ch.out_unit,
               out_ch.run_last, out_ch.string_done);
        err_cnt = err_cnt + 1;
      end else begin
        want = escaped_expect.pop_front();
        if (out_ch.out_unit !== want.unit) begin
          $error("out_unit: expected %h, got %h", want.unit, out_ch.out_unit);
          err_cnt = err_cnt + 1;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
          err_cnt = err_cnt + 1;
        end
        if (out_ch.string_done !== want.done) begin
          $error("string_done: expected %b, got %b", want.done, out_ch.string_done);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] units[$];
    int          n_units;
    int          kind;
    logic        split_close;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    in_ch.first_unit = 1'b0;
    in_ch.last_unit = 1'b0;
    in_ch.no_unit = 1'b0;
    out_ch.ready = 1'b0;

    queue_word(16'h0041, 1'b1, 1'b0, 1'b0);
    queue_word(CH_QUOTE, 1'b0, 1'b0, 1'b0);
    queue_word(CH_BSLASH, 1'b0, 1'b0, 1'b0);
    queue_word(CTL_BSP, 1'b0, 1'b0, 1'b0);
    queue_word(CTL_FF, 1'b0, 1'b0, 1'b0);
    queue_word(CTL_LF, 1'b0, 1'b0, 1'b0);
    queue_word(CTL_CR, 1'b0, 1'b0, 1'b0);
    queue_word(CTL_TAB, 1'b0, 1'b0, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b0, 1'b0);
    queue_word(16'h001F, 1'b0, 1'b0, 1'b0);
    queue_word(CTRL_LIMIT, 1'b0, 1'b0, 1'b0);
    queue_word(SURR_BASE, 1'b0, 1'b0, 1'b0);
    queue_word(LOW_LAST, 1'b0, 1'b0, 1'b0);
    queue_word(HIGH_LAST, 1'b0, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b0, 1'b1);
    queue_word(LOW_FIRST, 1'b0, 1'b0, 1'b0);
    queue_word(LOW_FIRST, 1'b0, 1'b0, 1'b0);
    queue_word(16'hD83D, 1'b0, 1'b0, 1'b0);
    queue_word(16'h0041, 1'b0, 1'b0, 1'b0);
    queue_word(HIGH_LAST, 1'b0, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_word(16'hD801, 1'b0, 1'b0, 1'b0);
    queue_word(16'h0061, 1'b1, 1'b0, 1'b0);
    queue_word(16'hD802, 1'b0, 1'b0, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b1, 1'b1, 1'b1);
    drain_next = 1'b1;

    while (words_to_send.size() < 270) begin
      if (words_to_send.size() >= 170 && words_to_send.size() < 175) begin
        drain_next = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 78) begin
        n_units = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
        units.delete();
        while (units.size() < n_units) begin
          case ($urandom_range(9)) inside
            [0:3]: units.insert(units.size(), 16'($urandom_range(PRINT_LAST, CTRL_LIMIT)));
            4: units.insert(units.size(), ESC_SET[$urandom_range(6)]);
            5: units.insert(units.size(), 16'($urandom_range(CTRL_LIMIT - 1, 0)));
            6: begin
              units.insert(units.size(), 16'($urandom_range(HIGH_LAST, SURR_BASE)));
              units.insert(units.size(), 16'($urandom_range(LOW_LAST, LOW_FIRST)));
            end
            7: units.insert(units.size(), 16'($urandom_range(LOW_LAST, SURR_BASE)));
            default: units.insert(units.size(), 16'($urandom_range(16'hFFFF, 0)));
          endcase
        end
        split_close = ($urandom_range(6) == 0);
        if (units.size() == 0) begin
          if (split_close) begin
            queue_word(16'($urandom_range(16'hFFFF, 0)), 1'b1, 1'b0, 1'b1);
            queue_word(16'($urandom_range(16'hFFFF, 0)), 1'b0, 1'b1, 1'b1);
          end else begin
            queue_word(16'($urandom_range(16'hFFFF, 0)), 1'b1, 1'b1, 1'b1);
          end
        end else begin
          foreach (units[i]) begin
            queue_word(units[i], i == 0, (i == units.size() - 1) && !split_close, 1'b0);
          end
          if (split_close) begin
            queue_word(16'($urandom_range(16'hFFFF, 0)), 1'b0, 1'b1, 1'b1);
          end
        end
      end else if (kind < 90) begin
        queue_word(16'($urandom_range(16'hFFFF, 0)), 1'b0, 1'b0, 1'b1);
      end else begin
        n_units = $urandom_range(3, 1);
        for (int i = 0; i < n_units; i++) begin
          queue_word(16'($urandom_range(16'hFFFF, 0)), (i == 0) && ($urandom_range(1) == 1),
                     1'b0, 1'b0);
        end
      end
    end
    n_items = words_to_send.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (!(sent_cnt == n_items && escaped_expect.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
